[design/at_address_field_quoter_top_macros.svh]
// Assertion macros for the at_address_field_quoter block.
// Used by aafq_back in this folder; no other dependencies.
`ifndef AT_ADDRESS_FIELD_QUOTER_TOP_MACROS_SVH
`define AT_ADDRESS_FIELD_QUOTER_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define AAFQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define AAFQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `AAFQ_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

[design/aafq_pkg.sv]
// Package for the at_address_field_quoter block: phase enum, character codes,
// prefix text, queue command type and byte class helpers. No dependencies.
`default_nettype none

package aafq_pkg;

  typedef enum logic [2:0] {
    PH_SCAN,
    PH_HDR_BLANK,
    PH_HDR_DIGIT,
    PH_AFTER_COMMA,
    PH_LEAD,
    PH_IN_FIELD,
    PH_RAW_FIELD,
    PH_SKIP_LINE
  } aafq_phase_e;

  localparam int TAG_LEN = 9;
  localparam logic [7:0] TAG_TEXT [TAG_LEN] = '{
    8'h2B, 8'h43, 8'h47, 8'h50, 8'h41, 8'h44, 8'h44, 8'h52, 8'h3A
  };

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  localparam int QUEUE_DEPTH = 2;

  // Fixed part of one queued command; release count and blank snapshot travel beside it.
  typedef struct packed {
    logic [7:0] data;
    logic       quote;
    logic       ovf;
  } aafq_cmd_t;

  localparam int CMD_W = $bits(aafq_cmd_t);

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = b inside {CH_SPACE, CH_TAB};
  endfunction

  function automatic logic is_eol(input logic [7:0] b);
    is_eol = b inside {CH_CR, CH_LF};
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = b inside {[CH_ZERO:CH_NINE]};
  endfunction

endpackage

`default_nettype wire

[design/aafq_front.sv]
// Front end: accepts input bytes, tracks the line phase and held blanks, and
// issues one command per byte that yields output. Depends on aafq_pkg.
`default_nettype none

module aafq_front import aafq_pkg::*; #(
  parameter int BLANK_HOLD = 16,
  parameter int MAX_QUOTED = 4,
  localparam int CW = $clog2(BLANK_HOLD + 1),
  localparam int IW = (BLANK_HOLD > 1) ? $clog2(BLANK_HOLD) : 1,
  localparam int QW = $clog2(MAX_QUOTED + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  enable_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            in_byte_i,
  input  wire logic                  full_i,
  output logic                       push_o,
  output aafq_cmd_t                  cmd_o,
  output logic [CW-1:0]              rel_o,
  output logic [BLANK_HOLD-1:0]      blanks_o
);

  aafq_phase_e          phase_q, phase_d;
  logic [3:0]           prefix_q, prefix_d;
  logic [QW-1:0]        qf_q, qf_d;
  logic [CW-1:0]        pend_q, pend_d;
  logic [BLANK_HOLD-1:0] blanks_q;
  logic                 accept;
  logic                 hold;
  logic                 b_blank, b_eol, b_digit, b_comma, b_quote;
  logic                 pend_full;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign b_blank    = is_blank(in_byte_i);
  assign b_eol      = is_eol(in_byte_i);
  assign b_digit    = is_digit(in_byte_i);
  assign b_comma    = (in_byte_i == CH_COMMA);
  assign b_quote    = (in_byte_i == CH_QUOTE);
  assign pend_full  = (pend_q >= CW'(BLANK_HOLD));
  assign hold       = enable_i && (phase_q == PH_IN_FIELD) && b_blank && !pend_full;

  // Next state
  always_comb begin
    phase_d  = phase_q;
    prefix_d = prefix_q;
    qf_d     = qf_q;
    pend_d   = pend_q;
    if (accept) begin
      if (!enable_i) begin
        phase_d  = PH_SCAN;
        prefix_d = '0;
        qf_d     = '0;
        pend_d   = '0;
      end else begin
        case (phase_q)
          PH_SCAN: begin
            if (prefix_q < 4'(TAG_LEN) && in_byte_i == TAG_TEXT[prefix_q]) begin
              if (prefix_q == 4'(TAG_LEN - 1)) begin
                prefix_d = '0;
                qf_d     = '0;
                phase_d  = PH_HDR_BLANK;
              end else begin
                prefix_d = prefix_q + 4'd1;
              end
            end else begin
              prefix_d = (in_byte_i == CH_PLUS) ? 4'd1 : 4'd0;
            end
          end
          PH_HDR_BLANK, PH_HDR_DIGIT: begin
            if (b_eol) begin
              phase_d  = PH_SCAN;
              prefix_d = '0;
              qf_d     = '0;
            end else if (phase_q == PH_HDR_BLANK && b_blank) begin
              phase_d = phase_q;
            end else if (b_digit) begin
              phase_d = PH_HDR_DIGIT;
            end else if (b_comma) begin
              phase_d = PH_AFTER_COMMA;
            end else begin
              phase_d = PH_SKIP_LINE;
            end
          end
          PH_AFTER_COMMA, PH_LEAD: begin
            if (b_eol) begin
              phase_d  = PH_SCAN;
              prefix_d = '0;
              qf_d     = '0;
            end else if (phase_q == PH_AFTER_COMMA && b_quote) begin
              phase_d = PH_SKIP_LINE;
            end else if (b_blank || b_comma) begin
              phase_d = PH_LEAD;
            end else if (b_quote) begin
              phase_d = PH_RAW_FIELD;
            end else begin
              qf_d    = qf_q + QW'(1);
              pend_d  = '0;
              phase_d = PH_IN_FIELD;
            end
          end
          PH_IN_FIELD: begin
            if (b_blank) begin
              pend_d = pend_full ? '0 : pend_q + CW'(1);
            end else if (b_comma || b_eol) begin
              pend_d = '0;
              if (b_eol) begin
                phase_d  = PH_SCAN;
                prefix_d = '0;
                qf_d     = '0;
              end else if (qf_q >= QW'(MAX_QUOTED)) begin
                phase_d = PH_SKIP_LINE;
              end else begin
                phase_d = PH_LEAD;
              end
            end else begin
              pend_d = '0;
            end
          end
          PH_RAW_FIELD: begin
            if (b_eol) begin
              phase_d  = PH_SCAN;
              prefix_d = '0;
              qf_d     = '0;
            end else if (b_comma) begin
              phase_d = PH_LEAD;
            end
          end
          default: begin
            if (b_eol) begin
              phase_d  = PH_SCAN;
              prefix_d = '0;
              qf_d     = '0;
            end
          end
        endcase
      end
    end
  end

  // Command outputs
  always_comb begin
    push_o       = accept && !hold;
    cmd_o.data   = in_byte_i;
    cmd_o.quote  = 1'b0;
    cmd_o.ovf    = 1'b0;
    rel_o        = '0;
    blanks_o     = blanks_q;
    if (!enable_i) begin
      rel_o = pend_q;
    end else begin
      case (phase_q)
        PH_AFTER_COMMA, PH_LEAD: begin
          cmd_o.quote = !b_eol && !b_blank && !b_comma && !b_quote;
        end
        PH_IN_FIELD: begin
          if (b_blank) begin
            cmd_o.ovf = pend_full;
            rel_o     = pend_q;
          end else begin
            cmd_o.quote = b_comma || b_eol;
            rel_o       = pend_q;
          end
        end
        default: begin
          rel_o = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SCAN;
      prefix_q <= '0;
      qf_q     <= '0;
      pend_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      prefix_q <= prefix_d;
      qf_q     <= qf_d;
      pend_q   <= pend_d;
    end
  end

  // Held blank store, 1 = tab
  always_ff @(posedge clk_i) begin
    if (accept && hold) begin
      blanks_q[pend_q[IW-1:0]] <= (in_byte_i == CH_TAB);
    end
  end

endmodule

`default_nettype wire

[design/aafq_fifo.sv]
// Short command queue between front and back ends.
// Depends on aafq_pkg for the default depth QUEUE_DEPTH.
`default_nettype none

module aafq_fifo import aafq_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] din_i,
  input  wire logic         pop_i,
  output logic [W-1:0]      dout_o,
  output logic              empty_o,
  output logic              full_o
);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    next_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == NW'(DEPTH));
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= next_ptr(wr_q);
      end
      if (pop_i) begin
        rd_q <= next_ptr(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[design/aafq_back.sv]
// Back end: plays out one queued command as a quote, released blanks and the byte
// itself, one output transaction per cycle unless stalled. Uses aafq_pkg and macros.
`default_nettype none
`include "at_address_field_quoter_top_macros.svh"

module aafq_back import aafq_pkg::*; #(
  parameter int BLANK_HOLD = 16,
  localparam int CW = $clog2(BLANK_HOLD + 1),
  localparam int IW = (BLANK_HOLD > 1) ? $clog2(BLANK_HOLD) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire aafq_cmd_t             cmd_i,
  input  wire logic [CW-1:0]         rel_i,
  input  wire logic [BLANK_HOLD-1:0] blanks_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       out_last_of_run_o,
  output logic                       out_blank_overflow_o
);

  logic          quote_done_q;
  logic [CW-1:0] idx_q;
  logic          quote_pend, blank_pend, fire, last;

  assign quote_pend = cmd_i.quote && !quote_done_q;
  assign blank_pend = (idx_q < rel_i);
  assign last       = !quote_pend && !blank_pend;
  assign fire       = valid_i && !out_stall_i;
  assign pop_o      = fire && last;

  assign out_valid_o          = valid_i;
  assign out_last_of_run_o    = last;
  assign out_blank_overflow_o = cmd_i.ovf;

  always_comb begin
    if (quote_pend) begin
      out_byte_o = CH_QUOTE;
    end else if (blank_pend) begin
      out_byte_o = blanks_i[idx_q[IW-1:0]] ? CH_TAB : CH_SPACE;
    end else begin
      out_byte_o = cmd_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_done_q <= 1'b0;
      idx_q        <= '0;
    end else if (fire) begin
      if (last) begin
        quote_done_q <= 1'b0;
        idx_q        <= '0;
      end else if (quote_pend) begin
        quote_done_q <= 1'b1;
      end else begin
        idx_q <= idx_q + CW'(1);
      end
    end
  end

  `AAFQ_ASSERT(a_pop_on_final, clk_i, rst_ni, pop_o |-> (out_valid_o && !out_stall_i && last), "pop without final transaction")
  `AAFQ_ASSERT(a_idx_bound, clk_i, rst_ni, valid_i |-> (idx_q <= rel_i), "blank index past release count")
  `AAFQ_ASSERT(a_quote_first, clk_i, rst_ni, (valid_i && idx_q != '0) |-> (quote_done_q || !cmd_i.quote), "blank sent before opening quote")
  `AAFQ_ASSERT_NEVER(a_idle_progress, clk_i, rst_ni, !valid_i && (quote_done_q || idx_q != '0), "progress held with empty queue")

endmodule

`default_nettype wire

[design/at_address_field_quoter_top.sv]
// Top level of the address field quoter: configuration register, front end,
// command queue and back end. Depends on aafq_pkg, aafq_front, aafq_fifo, aafq_back.
//
// Usage: bytes of a modem response enter on in_valid_i/in_byte_i and are accepted
// when in_stall_o is low. Each accepted byte yields zero to BLANK_HOLD+2 output
// transactions on out_valid_o/out_byte_o, the final one marked by
// out_last_of_run_o; out_blank_overflow_o flags every transaction of a byte whose
// blank overflowed the held-blank store. Blanks held inside a field produce none.
// Throughput: the front takes one byte per cycle while the two-entry command queue
// has room; the back gives one transaction per unstalled cycle, so a byte holds
// the back to its last output and a long release stalls input via the queue.
// Stall on the output holds the current transaction; the queue then fills and
// in_stall_o rises. cfg_we_i writes rewrite_enable (cfg_wdata_i); the user must
// do so only while idle, and the block itself does not enforce this.
// Reset: rewrite_enable = 1, scanning for the prefix, queue empty; no clearing pass.
`default_nettype none

module at_address_field_quoter_top import aafq_pkg::*; #(
  parameter int BLANK_HOLD = 16,
  parameter int MAX_QUOTED = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_of_run_o,
  output logic            out_blank_overflow_o
);

  localparam int CW = $clog2(BLANK_HOLD + 1);
  localparam int QWD = CMD_W + CW + BLANK_HOLD;

  logic                  enable_q;
  logic                  push, pop, empty, full;
  aafq_cmd_t             f_cmd, b_cmd;
  logic [CW-1:0]         f_rel, b_rel;
  logic [BLANK_HOLD-1:0] f_blanks, b_blanks;
  logic [QWD-1:0]        q_din, q_dout;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  aafq_front #(
    .BLANK_HOLD (BLANK_HOLD),
    .MAX_QUOTED (MAX_QUOTED)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enable_i   (enable_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (f_cmd),
    .rel_o      (f_rel),
    .blanks_o   (f_blanks)
  );

  assign q_din = {f_cmd, f_rel, f_blanks};

  aafq_fifo #(
    .W     (QWD),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (q_din),
    .pop_i   (pop),
    .dout_o  (q_dout),
    .empty_o (empty),
    .full_o  (full)
  );

  assign b_cmd    = q_dout[QWD-1 -: CMD_W];
  assign b_rel    = q_dout[BLANK_HOLD +: CW];
  assign b_blanks = q_dout[BLANK_HOLD-1:0];

  aafq_back #(
    .BLANK_HOLD (BLANK_HOLD)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .valid_i              (!empty),
    .cmd_i                (b_cmd),
    .rel_i                (b_rel),
    .blanks_i             (b_blanks),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_byte_o           (out_byte_o),
    .out_last_of_run_o    (out_last_of_run_o),
    .out_blank_overflow_o (out_blank_overflow_o)
  );

endmodule

`default_nettype wire
